// ----- src/npe_pkg.sv -----
// Shared constants and types for the NMEA position extractor.
package npe_pkg;

   // Register defaults
   localparam logic [5:0] STATUS_OFFSET_RESET  = 6'd18;
   localparam logic [3:0] HEMISPHERE_GAP_RESET = 4'd3;

   // Register indexes, taken from paddr[2]
   localparam logic CSR_IDX_STATUS_OFFSET  = 1'b0;
   localparam logic CSR_IDX_HEMISPHERE_GAP = 1'b1;

   // Fraction digits per coordinate
   localparam int FRACTION_DIGITS_DEFAULT = 4;

   // Characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   // Arithmetic bounds and scale factors
   localparam logic [16:0] INT_CAP       = 17'd131071;
   localparam logic [25:0] LAT_CAP       = 26'd59999999;
   localparam logic [29:0] LON_CAP       = 30'd599999999;
   localparam logic [19:0] DEG_UNITS     = 20'd600000;
   localparam logic [13:0] MIN_UNITS     = 14'd10000;
   // Degree units for a saturated integer part (131071 -> 1310 deg, 71 min)
   localparam logic [29:0] DEG_SAT_UNITS = 30'd786000000;
   localparam logic [3:0]  SAT_TENS      = 4'd7;
   localparam logic [3:0]  SAT_ONES      = 4'd1;

   // Accumulator controls from the parse sequencer
   typedef struct packed {
      logic clear_int;
      logic add_int;
      logic clear_frac;
      logic add_frac;
   } acc_ctrl_type;

endpackage

// ----- src/npe_if.sv -----
// Handshake channels of the NMEA position extractor.
interface npe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface npe_rsp_if;
   logic        valid;
   logic        ready;
   logic        fix_valid;
   logic [25:0] latitude_units;
   logic [29:0] longitude_units;

   modport source (output valid, output fix_valid, output latitude_units,
                   output longitude_units, input ready);
   modport sink   (input valid, input fix_valid, input latitude_units,
                   input longitude_units, output ready);
endinterface

// ----- src/npe_coord_acc.sv -----
// Digit accumulator: integer part split into degrees and minutes, fraction, unit sum.
module npe_coord_acc #(
   parameter int FRACTION_DIGITS = npe_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic                 clock,
   input  logic [7:0]           rx_byte,
   input  npe_pkg::acc_ctrl_type ctrl,
   output logic                 frac_done,
   output logic [30:0]          coord_raw
);

   localparam int         FRAC_SCALE = 10 ** (4 - FRACTION_DIGITS);
   localparam logic [2:0] FD_COUNT   = 3'(FRACTION_DIGITS);

   logic [16:0] int_ff,   int_in;
   logic [29:0] deg_ff,   deg_in;
   logic [3:0]  tens_ff,  tens_in;
   logic [3:0]  ones_ff,  ones_in;
   logic [13:0] frac_ff,  frac_in;
   logic [2:0]  fcount_ff, fcount_in;

   logic        is_digit;
   logic [3:0]  digit;
   logic [20:0] int_prod;
   logic        int_sat;
   logic [23:0] tens_units;
   logic [29:0] deg_step;
   logic [17:0] frac_prod;
   logic [13:0] frac_new;
   logic [2:0]  fcount_new;
   logic [6:0]  minutes;
   logic [23:0] min_units;
   logic [24:0] frac_units;

   always_comb begin
      is_digit   = (rx_byte >= npe_pkg::CHAR_ZERO) && (rx_byte <= npe_pkg::CHAR_NINE);
      digit      = is_digit ? 4'(rx_byte - npe_pkg::CHAR_ZERO) : 4'd0;

      // integer part: binary value for saturation, split value for conversion
      int_prod   = 21'({int_ff, 3'b000}) + 21'({int_ff, 1'b0}) + 21'(digit);
      int_sat    = int_prod > 21'(npe_pkg::INT_CAP);
      tens_units = 24'(tens_ff) * 24'(npe_pkg::DEG_UNITS);
      deg_step   = 30'({deg_ff, 3'b000}) + 30'({deg_ff, 1'b0}) + 30'(tens_units);

      // fraction, non-digits count as zero
      frac_prod  = 18'({frac_ff, 3'b000}) + 18'({frac_ff, 1'b0}) + 18'(digit);
      frac_new   = frac_prod[13:0];
      fcount_new = fcount_ff + 3'd1;
      frac_done  = fcount_new >= FD_COUNT;

      minutes    = 7'(tens_ff) * 7'd10 + 7'(ones_ff);
      min_units  = 24'(minutes) * 24'(npe_pkg::MIN_UNITS);
      frac_units = 25'(frac_new) * 25'(FRAC_SCALE);
      coord_raw  = 31'(deg_ff) + 31'(min_units) + 31'(frac_units);

      int_in    = int_ff;
      deg_in    = deg_ff;
      tens_in   = tens_ff;
      ones_in   = ones_ff;
      frac_in   = frac_ff;
      fcount_in = fcount_ff;

      if (ctrl.clear_int) begin
         int_in  = '0;
         deg_in  = '0;
         tens_in = '0;
         ones_in = '0;
      end else if (ctrl.add_int && is_digit) begin
         if (int_sat) begin
            int_in  = npe_pkg::INT_CAP;
            deg_in  = npe_pkg::DEG_SAT_UNITS;
            tens_in = npe_pkg::SAT_TENS;
            ones_in = npe_pkg::SAT_ONES;
         end else begin
            int_in  = int_prod[16:0];
            deg_in  = deg_step;
            tens_in = ones_ff;
            ones_in = digit;
         end
      end

      if (ctrl.clear_frac) begin
         frac_in   = '0;
         fcount_in = '0;
      end else if (ctrl.add_frac) begin
         frac_in   = frac_new;
         fcount_in = fcount_new;
      end
   end

   always_ff @(posedge clock) begin
      int_ff    <= int_in;
      deg_ff    <= deg_in;
      tens_ff   <= tens_in;
      ones_ff   <= ones_in;
      frac_ff   <= frac_in;
      fcount_ff <= fcount_in;
   end

endmodule

// ----- src/nmea_position_extractor.sv -----
// Top level of the NMEA position extractor: byte sequencer, registers, result stage.
// Throughput: one byte per cycle while req is ready; each byte updates the parse state at once.
// A result appears on rsp in the cycle after the byte transfer that causes it.
// The result register holds one item; req stays ready while that slot is empty or taken.
// Reset clears the parse state to hunting, empties the result slot and loads
// status_offset = 18 and hemisphere_gap = 3; accumulators clear when a fix starts.
module nmea_position_extractor #(
   parameter int FRACTION_DIGITS = npe_pkg::FRACTION_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   npe_req_if.sink     req_chan,
   npe_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [7:0] {
      PH_HUNT     = 8'b0000_0001,
      PH_COUNT    = 8'b0000_0010,
      PH_LAT_INT  = 8'b0000_0100,
      PH_LAT_FRAC = 8'b0000_1000,
      PH_GAP      = 8'b0001_0000,
      PH_LON_INT  = 8'b0010_0000,
      PH_LON_FRAC = 8'b0100_0000,
      PH_WAIT_LF  = 8'b1000_0000
   } phase_type;

   // Configuration registers
   logic [5:0] status_offset_ff;
   logic [3:0] hemisphere_gap_ff;
   logic       csr_write;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [5:0]  byte_count_ff, byte_count_in;
   logic [25:0] lat_ff, lat_in;
   logic [29:0] lon_ff, lon_in;

   // Result stage
   logic        rsp_valid_ff;
   logic        fix_valid_ff;
   logic [25:0] rsp_lat_ff;
   logic [29:0] rsp_lon_ff;

   logic        accept;
   logic [7:0]  rx;
   logic [5:0]  count_next;
   logic        emit;
   logic        emit_fix;
   logic [25:0] emit_lat;
   logic [29:0] emit_lon;
   logic [25:0] lat_sat;
   logic [29:0] lon_sat;

   npe_pkg::acc_ctrl_type acc_ctrl;
   logic                  frac_done;
   logic [30:0]           coord_raw;

   // ---------------------------------------------------------------- CSR port
   // Write on the access phase; pready is tied high so no access is ever stretched by wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         npe_pkg::CSR_IDX_STATUS_OFFSET:  csr_prdata = {26'd0, status_offset_ff};
         npe_pkg::CSR_IDX_HEMISPHERE_GAP: csr_prdata = {28'd0, hemisphere_gap_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_offset_ff  <= npe_pkg::STATUS_OFFSET_RESET;
         hemisphere_gap_ff <= npe_pkg::HEMISPHERE_GAP_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == npe_pkg::CSR_IDX_STATUS_OFFSET) begin
            status_offset_ff <= csr_pwdata[5:0];
         end else begin
            hemisphere_gap_ff <= csr_pwdata[3:0];
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   // Take a new byte whenever the result slot is free or drains this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;

   // ---------------------------------------------------------------- digits
   npe_coord_acc #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_coord_acc (
      .clock     (clock),
      .rx_byte   (rx),
      .ctrl      (acc_ctrl),
      .frac_done (frac_done),
      .coord_raw (coord_raw)
   );

   // Clamp the converted coordinate at its bound.
   assign lat_sat = (coord_raw > 31'(npe_pkg::LAT_CAP)) ? npe_pkg::LAT_CAP : coord_raw[25:0];
   assign lon_sat = (coord_raw > 31'(npe_pkg::LON_CAP)) ? npe_pkg::LON_CAP : coord_raw[29:0];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      lat_in        = lat_ff;
      lon_in        = lon_ff;
      acc_ctrl      = '0;
      emit          = 1'b0;
      emit_fix      = 1'b0;
      emit_lat      = '0;
      emit_lon      = '0;
      count_next    = byte_count_ff + 6'd1;

      if (accept) begin
         if ((phase_ff inside {PH_LAT_INT, PH_LAT_FRAC, PH_GAP, PH_LON_INT, PH_LON_FRAC})
             && (rx == npe_pkg::CHAR_LF)) begin
            // sentence ended before both coordinates were complete
            phase_in = PH_HUNT;
            emit     = 1'b1;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (rx == npe_pkg::CHAR_DOLLAR) begin
                     byte_count_in = '0;
                     phase_in      = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  // equality compare: an offset already passed waits for wrap
                  byte_count_in = count_next;
                  if (count_next == status_offset_ff) begin
                     if (rx != npe_pkg::CHAR_A) begin
                        phase_in = PH_HUNT;
                        emit     = 1'b1;
                     end else begin
                        acc_ctrl.clear_int  = 1'b1;
                        acc_ctrl.clear_frac = 1'b1;
                        lat_in              = '0;
                        lon_in              = '0;
                        phase_in            = PH_LAT_INT;
                     end
                  end
               end
               PH_LAT_INT: begin
                  if (rx == npe_pkg::CHAR_DOT) begin
                     acc_ctrl.clear_frac = 1'b1;
                     phase_in            = PH_LAT_FRAC;
                  end else begin
                     acc_ctrl.add_int = 1'b1;
                  end
               end
               PH_LON_INT: begin
                  if (rx == npe_pkg::CHAR_DOT) begin
                     acc_ctrl.clear_frac = 1'b1;
                     phase_in            = PH_LON_FRAC;
                  end else begin
                     acc_ctrl.add_int = 1'b1;
                  end
               end
               PH_LAT_FRAC: begin
                  acc_ctrl.add_frac = 1'b1;
                  if (frac_done) begin
                     lat_in             = lat_sat;
                     acc_ctrl.clear_int = 1'b1;
                     byte_count_in      = '0;
                     phase_in           = (hemisphere_gap_ff == 4'd0) ? PH_LON_INT : PH_GAP;
                  end
               end
               PH_GAP: begin
                  byte_count_in = count_next;
                  if (count_next >= 6'(hemisphere_gap_ff)) begin
                     phase_in = PH_LON_INT;
                  end
               end
               PH_LON_FRAC: begin
                  acc_ctrl.add_frac = 1'b1;
                  if (frac_done) begin
                     lon_in   = lon_sat;
                     phase_in = PH_WAIT_LF;
                  end
               end
               PH_WAIT_LF: begin
                  if (rx == npe_pkg::CHAR_LF) begin
                     phase_in = PH_HUNT;
                     emit     = 1'b1;
                     emit_fix = 1'b1;
                     emit_lat = lat_ff;
                     emit_lon = lon_ff;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         byte_count_ff <= '0;
         lat_ff        <= '0;
         lon_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         lat_ff        <= lat_in;
         lon_ff        <= lon_in;
      end
   end

   // ---------------------------------------------------------------- result stage
   // Load on emit; otherwise drop valid once the sink takes the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         fix_valid_ff <= emit_fix;
         rsp_lat_ff   <= emit_lat;
         rsp_lon_ff   <= emit_lon;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.fix_valid       = fix_valid_ff;
   assign rsp_chan.latitude_units  = rsp_lat_ff;
   assign rsp_chan.longitude_units = rsp_lon_ff;

endmodule
